>>> rtl/ncmc_pkg.sv
// Shared constants and types for the nanosecond / counter-tick converter.
package ncmc_pkg;

  // Direction codes carried on op
  localparam logic OP_NS_TO_CNT = 1'b0;
  localparam logic OP_CNT_TO_NS = 1'b1;

  // Nanoseconds in one second
  localparam logic [31:0] NS_PER_SEC = 32'd1_000_000_000;

  // Operand and product widths
  localparam int unsigned VAL_W   = 64;
  localparam int unsigned FACT_W  = 32;
  localparam int unsigned PROD_W  = VAL_W + FACT_W;
  localparam int unsigned ACC_W   = PROD_W + FACT_W;

  // One quotient bit is settled per division cell
  localparam int unsigned DIV_STEPS = PROD_W;

  // Payload handed from stage to stage along the division chain.
  // acc holds {partial remainder, unconsumed dividend bits, quotient bits}.
  typedef struct packed {
    logic              div_zero;
    logic [ACC_W-1:0]  acc;
    logic [FACT_W-1:0] divisor;
  } ncmc_work_t;

endpackage

>>> rtl/ncmc_mul.sv
// Two-stage 64 x 32 multiplier that forms the 96-bit product and loads the division chain.
module ncmc_mul (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          vld_i,
  input  logic                          op_i,
  input  logic [ncmc_pkg::VAL_W-1:0]    value_i,
  input  logic [ncmc_pkg::FACT_W-1:0]   freq_i,
  output logic                          vld_o,
  output ncmc_pkg::ncmc_work_t          work_o
);
  import ncmc_pkg::*;

  logic [FACT_W-1:0]   mult_d;
  logic [FACT_W-1:0]   divs_d;
  logic [2*FACT_W-1:0] plo_d;

  logic                vld1_q;
  logic [FACT_W-1:0]   a_hi_q;
  logic [FACT_W-1:0]   mult_q;
  logic [FACT_W-1:0]   divs_q;
  logic [2*FACT_W-1:0] plo_q;

  logic [2*FACT_W-1:0] phi_d;
  logic                vld2_q;
  ncmc_work_t          work_q;

  // Pick multiplier and divisor by direction
  always_comb begin
    if (op_i == OP_CNT_TO_NS) begin
      mult_d = NS_PER_SEC;
      divs_d = freq_i;
    end else begin
      mult_d = freq_i;
      divs_d = NS_PER_SEC;
    end
    plo_d = {{FACT_W{1'b0}}, value_i[FACT_W-1:0]} * {{FACT_W{1'b0}}, mult_d};
  end

  // Stage one: low partial product
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
    end else begin
      vld1_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    a_hi_q <= value_i[VAL_W-1:FACT_W];
    mult_q <= mult_d;
    divs_q <= divs_d;
    plo_q  <= plo_d;
  end

  // Stage two: high partial product plus carry-in of the low half
  assign phi_d = {{FACT_W{1'b0}}, a_hi_q} * {{FACT_W{1'b0}}, mult_q}
               + {{FACT_W{1'b0}}, plo_q[2*FACT_W-1:FACT_W]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld2_q <= 1'b0;
    end else begin
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q.div_zero <= (divs_q == '0);
    work_q.acc      <= {{FACT_W{1'b0}}, phi_d, plo_q[FACT_W-1:0]};
    work_q.divisor  <= divs_q;
  end

  assign vld_o  = vld2_q;
  assign work_o = work_q;

endmodule

>>> rtl/ncmc_cell.sv
// One restoring-division cell: settles a single quotient bit and passes the item on.
module ncmc_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 vld_i,
  input  ncmc_pkg::ncmc_work_t work_i,
  output logic                 vld_o,
  output ncmc_pkg::ncmc_work_t work_o
);
  import ncmc_pkg::*;

  logic [FACT_W:0]   trial;
  logic [FACT_W:0]   diff;
  logic              qbit;
  logic [FACT_W-1:0] rem_d;
  logic              vld_q;
  ncmc_work_t        work_q;

  // Shift in the next dividend bit and try the subtraction
  always_comb begin
    trial = {work_i.acc[ACC_W-1:PROD_W], work_i.acc[PROD_W-1]};
    diff  = trial - {1'b0, work_i.divisor};
    qbit  = (trial >= {1'b0, work_i.divisor});
    rem_d = qbit ? diff[FACT_W-1:0] : trial[FACT_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  // Advance the item with the new remainder and quotient bit
  always_ff @(posedge clk_i) begin
    work_q.div_zero <= work_i.div_zero;
    work_q.acc      <= {rem_d, work_i.acc[PROD_W-2:0], qbit};
    work_q.divisor  <= work_i.divisor;
  end

  assign vld_o  = vld_q;
  assign work_o = work_q;

endmodule

>>> rtl/ns_count_muldiv_converter.sv
// Top level of the nanosecond / counter-tick converter: multiplier, division chain, output.
//
// Converts a 64-bit value as floor(value * b / c), with b = counter_freq and c = 10^9 when
// op is 0, and b = 10^9 and c = counter_freq when op is 1. A new item is taken on every
// clock cycle (busy never rises) and its result appears on a one-cycle done_o strobe after
// two multiplier stages, 96 division cells settling one quotient bit each, and the output
// register. The receiver cannot stall; results must be taken as they come. A zero divisor
// gives result 0 with div_zero set; a quotient wider than 64 bits keeps its low 64 bits and
// sets overflow. Write counter_freq only while no item is in flight.
module ns_count_muldiv_converter (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [ncmc_pkg::FACT_W-1:0] cfg_wdata_i,
  input  logic                        start,
  output logic                        busy,
  input  logic                        op_i,
  input  logic [ncmc_pkg::VAL_W-1:0]  value_i,
  output logic                        done_o,
  output logic [ncmc_pkg::VAL_W-1:0]  result_o,
  output logic                        div_zero_o,
  output logic                        overflow_o
);
  import ncmc_pkg::*;

  logic [FACT_W-1:0] freq_q;
  logic              accept;

  logic              chain_vld  [DIV_STEPS+1];
  ncmc_work_t        chain_work [DIV_STEPS+1];

  ncmc_work_t        last_work;
  logic              done_q;
  logic [VAL_W-1:0]  result_q;
  logic              div_zero_q;
  logic              overflow_q;

  // Counter frequency register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_q <= '0;
    end else if (cfg_we_i) begin
      freq_q <= cfg_wdata_i;
    end
  end

  // The pipeline never holds off an item
  assign busy   = 1'b0;
  assign accept = start && !busy;

  ncmc_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vld_i   (accept),
    .op_i    (op_i),
    .value_i (value_i),
    .freq_i  (freq_q),
    .vld_o   (chain_vld[0]),
    .work_o  (chain_work[0])
  );

  // Division chain, one quotient bit per cell, most significant first
  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    ncmc_cell u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .vld_i  (chain_vld[i]),
      .work_i (chain_work[i]),
      .vld_o  (chain_vld[i+1]),
      .work_o (chain_work[i+1])
    );
  end

  assign last_work = chain_work[DIV_STEPS];

  // Output register: drop quotient on zero divisor, flag any upper quotient bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= chain_vld[DIV_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    div_zero_q <= last_work.div_zero;
    if (last_work.div_zero) begin
      result_q   <= '0;
      overflow_q <= 1'b0;
    end else begin
      result_q   <= last_work.acc[VAL_W-1:0];
      overflow_q <= |last_work.acc[PROD_W-1:VAL_W];
    end
  end

  assign done_o     = done_q;
  assign result_o   = result_q;
  assign div_zero_o = div_zero_q;
  assign overflow_o = overflow_q;

endmodule

>>> tb/sv/tb_ns_count_muldiv_converter.sv
// Testbench for the nanosecond / counter-tick converter: directed and random items checked by a local predictor.
module tb_ns_count_muldiv_converter;
  timeunit 1ns;
  timeprecision 1ps;

  import ncmc_pkg::*;

  typedef struct packed {
    logic [VAL_W-1:0] result;
    logic             div_zero;
    logic             overflow;
  } conv_res_t;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              cfg_we_i    = 1'b0;
  logic [FACT_W-1:0] cfg_wdata_i = '0;
  logic              start       = 1'b0;
  logic              busy;
  logic              op_i        = OP_NS_TO_CNT;
  logic [VAL_W-1:0]  value_i     = '0;
  logic              done_o;
  logic [VAL_W-1:0]  result_o;
  logic              div_zero_o;
  logic              overflow_o;

  // Local copy of the frequency register, reset value 0
  logic [FACT_W-1:0] freq_model = '0;
  conv_res_t         conv_due_q[$];
  int unsigned       mismatch_cnt = 0;
  // Chance in a hundred that the sender idles on a given cycle
  int unsigned       idle_pct = 0;

  ns_count_muldiv_converter u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .start       (start),
    .busy        (busy),
    .op_i        (op_i),
    .value_i     (value_i),
    .done_o      (done_o),
    .result_o    (result_o),
    .div_zero_o  (div_zero_o),
    .overflow_o  (overflow_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Expected conversion: floor(value * b / c) over the full product width
  function automatic conv_res_t scale_value(input logic op, input logic [VAL_W-1:0] val,
                                            input logic [FACT_W-1:0] freq);
    logic [FACT_W-1:0] mult;
    logic [FACT_W-1:0] dvsr;
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] quot;
    conv_res_t         res;
    mult = (op == OP_NS_TO_CNT) ? freq : NS_PER_SEC;
    dvsr = (op == OP_NS_TO_CNT) ? NS_PER_SEC : freq;
    res  = '0;
    if (dvsr == '0) begin
      res.div_zero = 1'b1;
    end else begin
      prod         = PROD_W'(val) * PROD_W'(mult);
      quot         = prod / PROD_W'(dvsr);
      res.result   = quot[VAL_W-1:0];
      res.overflow = |quot[PROD_W-1:VAL_W];
    end
    return res;
  endfunction

  // Check each result against the oldest expectation, then record any item taken
  always @(posedge clk_i) begin : mon
    conv_res_t got;
    conv_res_t want;
    if (rst_ni) begin
      if (done_o !== 1'b0) begin
        got = '{result_o, div_zero_o, overflow_o};
        if (conv_due_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("unexpected result: result %h div_zero %b overflow %b",
                     got.result, got.div_zero, got.overflow);
        end else begin
          want = conv_due_q.pop_front();
          if (got !== want) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("mismatch (exp/act): result %h/%h div_zero %b/%b overflow %b/%b",
                       want.result, got.result, want.div_zero, got.div_zero,
                       want.overflow, got.overflow);
          end
        end
      end
      if (start && busy === 1'b0)
        conv_due_q.push_back(scale_value(op_i, value_i, freq_model));
    end
  end

  // Present one item, idling first at random, and hold it until taken
  task automatic send_item(input logic op, input logic [VAL_W-1:0] val);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start   <= 1'b1;
    op_i    <= op;
    value_i <= val;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
  endtask

  // Drop start and hold until every expected result has come
  task automatic wait_results();
    start <= 1'b0;
    @(posedge clk_i);
    while (conv_due_q.size() != 0) @(posedge clk_i);
  endtask

  // Write the frequency register once the block is empty
  task automatic write_freq(input logic [FACT_W-1:0] freq);
    wait_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= freq;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    freq_model  = freq;
  endtask

  // Frequency still at reset: zero factor one way, zero divisor the other
  task automatic test_reset_freq();
    send_item(OP_NS_TO_CNT, '1);
    send_item(OP_CNT_TO_NS, 64'd12345);
    send_item(OP_CNT_TO_NS, '1);
  endtask

  // Largest frequency: widest product, overflow towards ticks
  task automatic test_max_freq();
    write_freq('1);
    send_item(OP_NS_TO_CNT, '0);
    send_item(OP_NS_TO_CNT, '1);
    send_item(OP_CNT_TO_NS, '1);
    send_item(OP_CNT_TO_NS, 64'd1);
  endtask

  // Frequency of 1 Hz: the last tick count that fits and the first that does not
  task automatic test_overflow_knee();
    write_freq(32'd1);
    send_item(OP_CNT_TO_NS, 64'd18446744073);
    send_item(OP_CNT_TO_NS, 64'd18446744074);
    send_item(OP_CNT_TO_NS, '1);
    send_item(OP_CNT_TO_NS, '0);
    send_item(OP_NS_TO_CNT, '1);
  endtask

  // One gigahertz: both directions are the identity
  task automatic test_unity_freq();
    write_freq(NS_PER_SEC);
    send_item(OP_NS_TO_CNT, '1);
    send_item(OP_CNT_TO_NS, '1);
    send_item(OP_NS_TO_CNT, {$urandom, $urandom});
    send_item(OP_CNT_TO_NS, {$urandom, $urandom});
  endtask

  // Frequency written back to zero after use
  task automatic test_zero_rewrite();
    write_freq('0);
    send_item(OP_CNT_TO_NS, {$urandom, $urandom});
    send_item(OP_NS_TO_CNT, {$urandom, $urandom});
  endtask

  // Blocks of random items, each block under its own frequency and idling
  task automatic test_random_traffic();
    logic [FACT_W-1:0]  freq;
    logic [FACT_W-1:0]  mult;
    logic [FACT_W-1:0]  dvsr;
    logic [VAL_W-1:0]   val;
    logic [2*VAL_W-1:0] knee;
    logic               op;
    int unsigned        sel;
    for (int blk = 0; blk < 30; blk++) begin
      sel = (blk < 6) ? blk : $urandom_range(5);
      case (sel)
        0:       freq = '0;
        1:       freq = '1;
        2:       freq = $urandom;
        3:       freq = $urandom_range(1, 1000);
        4:       freq = NS_PER_SEC;
        default: freq = $urandom_range(1, 100_000_000);
      endcase
      write_freq(freq);
      // Receivers cannot stall here, so phases 0 and 2 run without idling
      case (blk % 4)
        0:       idle_pct = 0;
        1:       idle_pct = 62;
        2:       idle_pct = 0;
        default: idle_pct = 24;
      endcase
      for (int i = 0; i < 55; i++) begin
        op = 1'($urandom_range(1));
        case ($urandom_range(4))
          0: val = {$urandom, $urandom};
          1: val = VAL_W'($urandom_range(0, 5000));
          2: val = {$urandom, $urandom} >> $urandom_range(63);
          3: begin
            // Aim at the value where the quotient stops fitting in 64 bits
            mult = (op == OP_NS_TO_CNT) ? freq : NS_PER_SEC;
            dvsr = (op == OP_NS_TO_CNT) ? NS_PER_SEC : freq;
            if (mult == '0 || dvsr == '0) begin
              val = {$urandom, $urandom};
            end else begin
              knee = ((2*VAL_W)'(1) << VAL_W) * (2*VAL_W)'(dvsr) / (2*VAL_W)'(mult);
              if (|knee[2*VAL_W-1:VAL_W])
                val = '1 - VAL_W'($urandom_range(0, 3));
              else
                val = knee[VAL_W-1:0] + VAL_W'($urandom_range(0, 4)) - VAL_W'(2);
            end
          end
          default: val = $urandom_range(1) ? '1 : VAL_W'(1) << $urandom_range(63);
        endcase
        send_item(op, val);
      end
    end
    idle_pct = 0;
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_freq();
    test_max_freq();
    test_overflow_knee();
    test_unity_freq();
    test_zero_rewrite();
    test_random_traffic();
    // Drain, then allow the pipeline depth for anything stray
    wait_results();
    repeat (110) @(posedge clk_i);
    if (mismatch_cnt == 0 && conv_due_q.size() == 0) begin
      $display("PASS ns_count_muldiv_converter");
    end else begin
      $display("FAIL ns_count_muldiv_converter");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #5_000_000;
    $display("FAIL ns_count_muldiv_converter");
    $finish;
  end

endmodule

>>> ns_count_muldiv_converter.f
rtl/ncmc_pkg.sv
rtl/ncmc_mul.sv
rtl/ncmc_cell.sv
rtl/ns_count_muldiv_converter.sv
tb/sv/tb_ns_count_muldiv_converter.sv
